@@ rtl/core/lstp_pkg.sv @@
// package for laser_scan_to_points: payload structs, register indexes,
// cordic arctangent table and state encoding. no dependencies.
`timescale 1ns / 1ps
package lstp_pkg;

    localparam int CordicStagesDef = 24;
    localparam int GuardBits       = 6;
    localparam int RangeW          = 24;
    localparam int CoordW          = 32;
    localparam int AngleW          = 32;
    // working width: 24 bit range + 6 guard bits + sign + gain growth
    localparam int WorkW           = 34;
    localparam logic [31:0] GainQ30 = 32'd652032874;
    localparam logic [23:0] MinRangeRst = 24'd13107;
    localparam logic [23:0] MaxRangeRst = 24'd6553600;

    typedef enum logic [2:0] {
        REG_START_ANGLE = 3'd0,
        REG_ANGLE_STEP  = 3'd1,
        REG_MOUNT_YAW   = 3'd2,
        REG_OFFSET_X    = 3'd3,
        REG_OFFSET_Y    = 3'd4,
        REG_MIN_RANGE   = 3'd5,
        REG_MAX_RANGE   = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_GAIN,
        ST_TRANSLATE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [23:0] range;
        logic        last_beam;
    } scan_in_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic               scan_end;
    } point_out_t;

    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/laser_scan_to_points.sv @@
// laser_scan_to_points top level: low-range substitution, beam angle, iterative cordic,
// serial gain multiply and saturating translation. uses lstp_pkg.
`timescale 1ns / 1ps
// channel   | ports                      | payload
// input     | s_valid s_ready s_data     | range, last_beam
// result    | m_valid m_ready m_data     | point_x, point_y, scan_end
// config    | cfg_we cfg_index cfg_wdata | seven registers, write only
// a result is offered once its input has passed through the cordic rotation,
// one cordic stage per cycle in a single shared rotator, then a bit-serial
// shift-add gain multiply, then a final translate and saturate step.
// a new input is taken only after the previous result has been accepted.
// reset clears control, the beam offset and the registers to their defaults.
// a stalled result holds in the output register; the next item waits.
module laser_scan_to_points #(
    parameter int CORDIC_STAGES = lstp_pkg::CordicStagesDef
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  lstp_pkg::scan_in_t     s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output lstp_pkg::point_out_t   m_data,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [31:0]            cfg_wdata
);
    localparam int W  = lstp_pkg::WorkW;
    localparam int PW = W + 32;          // gain product width
    localparam int TW = lstp_pkg::CoordW + 2;  // translate sum width
    localparam int SW = $clog2(CORDIC_STAGES + 1);
    localparam int MW = $clog2(W + 1);

    lstp_pkg::state_t state_reg, state_next;

    logic [31:0] start_angle_reg, angle_step_reg, mount_yaw_reg;
    logic signed [31:0] offset_x_reg, offset_y_reg;
    logic [23:0] min_range_reg, max_range_reg;
    logic [31:0] beam_off_reg;

    logic signed [W-1:0] x_reg, y_reg;
    logic signed [32:0]  z_reg;
    logic [SW-1:0]       step_reg;
    logic [MW-1:0]       mcnt_reg;
    logic signed [PW-1:0] px_reg, py_reg;
    logic                last_reg;
    lstp_pkg::point_out_t out_reg;

    logic signed [W-1:0] dx, dy;
    logic [31:0]         ang;
    logic signed [W-1:0] x_init;
    logic [23:0]         r_sel;
    logic signed [PW-1:0] gx, gy;
    logic signed [PW-37:0] rx, ry;
    logic signed [TW-1:0] tx, ty;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_angle_reg <= '0;
            angle_step_reg  <= '0;
            mount_yaw_reg   <= '0;
            offset_x_reg    <= '0;
            offset_y_reg    <= '0;
            min_range_reg   <= lstp_pkg::MinRangeRst;
            max_range_reg   <= lstp_pkg::MaxRangeRst;
        end else if (cfg_we) begin
            unique case (cfg_index)
                lstp_pkg::REG_START_ANGLE: start_angle_reg <= cfg_wdata;
                lstp_pkg::REG_ANGLE_STEP:  angle_step_reg  <= cfg_wdata;
                lstp_pkg::REG_MOUNT_YAW:   mount_yaw_reg   <= cfg_wdata;
                lstp_pkg::REG_OFFSET_X:    offset_x_reg    <= cfg_wdata;
                lstp_pkg::REG_OFFSET_Y:    offset_y_reg    <= cfg_wdata;
                lstp_pkg::REG_MIN_RANGE:   min_range_reg   <= cfg_wdata[23:0];
                lstp_pkg::REG_MAX_RANGE:   max_range_reg   <= cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    // start vector and angle folding
    always_comb begin
        r_sel  = (s_data.range <= min_range_reg) ? max_range_reg : s_data.range;
        ang    = start_angle_reg + beam_off_reg + mount_yaw_reg;
        x_init = W'({4'b0, r_sel, 6'b0});
    end

    assign dx = y_reg >>> step_reg;
    assign dy = x_reg >>> step_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lstp_pkg::ST_IDLE:
                if (s_valid) state_next = lstp_pkg::ST_ROTATE;
            lstp_pkg::ST_ROTATE:
                if (step_reg == SW'(CORDIC_STAGES - 1)) state_next = lstp_pkg::ST_GAIN;
            lstp_pkg::ST_GAIN:
                if (mcnt_reg == MW'(W - 1)) state_next = lstp_pkg::ST_TRANSLATE;
            lstp_pkg::ST_TRANSLATE:
                state_next = lstp_pkg::ST_OUT;
            lstp_pkg::ST_OUT:
                if (m_ready) state_next = lstp_pkg::ST_IDLE;
            default: state_next = lstp_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready = (state_reg == lstp_pkg::ST_IDLE);
        m_valid = (state_reg == lstp_pkg::ST_OUT);
        m_data  = out_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lstp_pkg::ST_IDLE;
            beam_off_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (s_valid && s_ready) begin
                beam_off_reg <= s_data.last_beam ? '0 : beam_off_reg + angle_step_reg;
            end
        end
    end

    // serial gain: add multiplicand shifted by the multiplier bit position
    always_comb begin
        gx = px_reg;
        gy = py_reg;
        if (lstp_pkg::GainQ30[mcnt_reg[4:0]] && mcnt_reg < MW'(32)) begin
            gx = px_reg + (PW'(x_reg) <<< mcnt_reg);
            gy = py_reg + (PW'(y_reg) <<< mcnt_reg);
        end
        rx = (PW-36)'((px_reg + (PW'(1) <<< 35)) >>> 36);
        ry = (PW-36)'((py_reg + (PW'(1) <<< 35)) >>> 36);
        tx = TW'(rx) + TW'(offset_x_reg);
        ty = TW'(ry) + TW'(offset_y_reg);
    end

    function automatic logic [31:0] sat(input logic signed [TW-1:0] v);
        logic [31:0] s;
        if (v > TW'(64'sh7fffffff)) s = 32'h7fffffff;
        else if (v < -TW'(64'sh80000000)) s = 32'h80000000;
        else s = v[31:0];
        return s;
    endfunction

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            lstp_pkg::ST_IDLE: begin
                step_reg <= '0;
                mcnt_reg <= '0;
                last_reg <= s_data.last_beam;
                y_reg    <= '0;
                if ($signed(ang) > 32'sh40000000) begin
                    z_reg <= $signed({ang[31], ang}) - 33'sh080000000;
                    x_reg <= -x_init;
                end else if ($signed(ang) < -32'sh40000000) begin
                    z_reg <= $signed({ang[31], ang}) + 33'sh080000000;
                    x_reg <= -x_init;
                end else begin
                    z_reg <= $signed({ang[31], ang});
                    x_reg <= x_init;
                end
            end
            lstp_pkg::ST_ROTATE: begin
                step_reg <= step_reg + 1'b1;
                px_reg   <= '0;
                py_reg   <= '0;
                if (!z_reg[32]) begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - $signed({1'b0, lstp_pkg::atan_lut(5'(step_reg))});
                end else begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + $signed({1'b0, lstp_pkg::atan_lut(5'(step_reg))});
                end
            end
            lstp_pkg::ST_GAIN: begin
                mcnt_reg <= mcnt_reg + 1'b1;
                px_reg   <= gx;
                py_reg   <= gy;
            end
            lstp_pkg::ST_TRANSLATE: begin
                out_reg.point_x  <= sat(tx);
                out_reg.point_y  <= sat(ty);
                out_reg.scan_end <= last_reg;
            end
            default: ;
        endcase
    end

    // result is offered only after translation
    a_valid_after_translate: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == lstp_pkg::ST_TRANSLATE)
        else $error("result without translate");
    // no input accepted while a result is pending
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result pending");
    // last beam returns the beam offset to zero
    a_offset_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.last_beam) |=> beam_off_reg == '0)
        else $error("beam offset not cleared");

endmodule
